[design/tpik_pkg.sv]
// ----------------------------------------------------------------------------
// tpik_pkg
// Shared constants, tables and types for the tilt platform IK pipeline.
// ----------------------------------------------------------------------------
package tpik_pkg;

  localparam int FRAC_BITS    = 8;
  localparam int GUARD        = 8;
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;

  localparam int VEC_W     = 36;  // vectoring datapath
  localparam int ANG_W     = 34;  // binary angles with headroom
  localparam int TRIG_W    = 32;  // Q30 sin/cos
  localparam int SQ_IN_W   = 56;
  localparam int SQ_ROOT_W = SQ_IN_W / 2;

  localparam int SQ_LAT     = SQ_ROOT_W;
  localparam int CORDIC_LAT = CORDIC_STEPS + 1;
  localparam int TEN_LAT    = 10;
  localparam int CNT_LAT    = 2;
  localparam int CNT_SHIFT  = FRAC_BITS + GUARD + 16;

  localparam logic signed [ANG_W-1:0] CORDIC_K = 34'sd652032874;
  localparam logic signed [ANG_W-1:0] QUARTER  = 34'sd1073741824;
  localparam logic signed [ANG_W-1:0] HALF     = 34'sd2147483648;

  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef enum logic [1:0] {
    REG_POLE_LENGTH   = 2'd0,
    REG_ANCHOR_RADIUS = 2'd1,
    REG_REST_LENGTH   = 2'd2,
    REG_COUNTS_PER_MM = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cc;
    logic signed [TRIG_W-1:0] sc;
    logic signed [TRIG_W-1:0] cb;
    logic signed [TRIG_W-1:0] sb;
  } trig_t;

  function automatic logic signed [ANG_W-1:0] atan_at(input int idx);
    logic [31:0] t;
    t = ATAN_TAB[idx];
    return signed'({2'b00, t});
  endfunction

endpackage

[design/tpik_isqrt.sv]
// ----------------------------------------------------------------------------
// tpik_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module tpik_isqrt import tpik_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [SQ_IN_W-1:0]   val_i,
  output logic [SQ_ROOT_W-1:0] root_o
);

  logic [SQ_IN_W-1:0] rem_r [SQ_LAT-1];
  logic [SQ_IN_W-1:0] res_r [SQ_LAT];

  for (genvar k = 0; k < SQ_LAT; k++) begin : g_step
    localparam logic [SQ_IN_W-1:0] BIT = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * k);
    logic [SQ_IN_W-1:0] rem_in, res_in, trial;
    logic               take;

    if (k == 0) begin : g_first
      assign rem_in = val_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end

    assign trial = res_in + BIT;
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        res_r[k] <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
      end
    end

    if (k < SQ_LAT - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? (rem_in - trial) : rem_in;
        end
      end
    end
  end

  assign root_o = res_r[SQ_LAT-1][SQ_ROOT_W-1:0];

endmodule

[design/tpik_cordic_vec.sv]
// ----------------------------------------------------------------------------
// tpik_cordic_vec
// Vectoring CORDIC: angle of (xv, yv) as a binary angle, zero vector gives 0.
// ----------------------------------------------------------------------------
module tpik_cordic_vec import tpik_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [32:0]      xv_i,
  input  logic signed [32:0]      yv_i,
  output logic signed [ANG_W-1:0] ang_o
);

  logic signed [VEC_W-1:0] xv_r  [CORDIC_STEPS+1];
  logic signed [VEC_W-1:0] yv_r  [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] ang_r [CORDIC_STEPS+1];
  logic                    zero_r [CORDIC_STEPS+1];

  logic signed [VEC_W-1:0] xe, ye, x0, y0;
  logic signed [ANG_W-1:0] a0;

  // quarter-turn pre-rotation into the right half plane
  always_comb begin
    xe = VEC_W'(xv_i);
    ye = VEC_W'(yv_i);
    x0 = xe;
    y0 = ye;
    a0 = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0 = ye;
        y0 = -xe;
        a0 = QUARTER;
      end else begin
        x0 = -ye;
        y0 = xe;
        a0 = -QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xv_r[0]   <= x0;
      yv_r[0]   <= y0;
      ang_r[0]  <= a0;
      zero_r[0] <= (xv_i == '0) && (yv_i == '0);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (yv_r[i] > 0) begin
          xv_r[i+1]  <= xv_r[i] + (yv_r[i] >>> i);
          yv_r[i+1]  <= yv_r[i] - (xv_r[i] >>> i);
          ang_r[i+1] <= ang_r[i] + atan_at(i);
        end else begin
          xv_r[i+1]  <= xv_r[i] - (yv_r[i] >>> i);
          yv_r[i+1]  <= yv_r[i] + (xv_r[i] >>> i);
          ang_r[i+1] <= ang_r[i] - atan_at(i);
        end
      end
    end
  end

  assign ang_o = zero_r[CORDIC_STEPS] ? '0 : ang_r[CORDIC_STEPS];

endmodule

[design/tpik_cordic_rot.sv]
// ----------------------------------------------------------------------------
// tpik_cordic_rot
// Rotation CORDIC: Q30 cosine and sine of a 32-bit binary angle.
// ----------------------------------------------------------------------------
module tpik_cordic_rot import tpik_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [31:0]              th_i,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  logic signed [ANG_W-1:0] x_r [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] y_r [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] z_r [CORDIC_STEPS+1];
  logic                    neg_r [CORDIC_STEPS+1];

  logic signed [ANG_W-1:0] zi, z0;
  logic                    n0;

  // fold into +-quarter turn, flip the result sign instead
  always_comb begin
    zi = ANG_W'(signed'(th_i));
    z0 = zi;
    n0 = 1'b0;
    if (zi > QUARTER) begin
      z0 = zi - HALF;
      n0 = 1'b1;
    end else if (zi < -QUARTER) begin
      z0 = zi + HALF;
      n0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= CORDIC_K;
      y_r[0]   <= '0;
      z_r[0]   <= z0;
      neg_r[0] <= n0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_at(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_at(i);
        end
      end
    end
  end

  logic signed [ANG_W-1:0] xf, yf;
  assign xf    = neg_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
  assign yf    = neg_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
  assign cos_o = xf[TRIG_W-1:0];
  assign sin_o = yf[TRIG_W-1:0];

endmodule

[design/tpik_tendon.sv]
// ----------------------------------------------------------------------------
// tpik_tendon
// Four rotations of one anchor through the pole transform, then the squared
// distance the anchor has moved.
// ----------------------------------------------------------------------------
module tpik_tendon import tpik_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] px_i,
  input  logic signed [31:0] py_i,
  input  logic signed [31:0] lg_i,
  input  trig_t              trig_i,
  output logic [SQ_IN_W-1:0] sum_o
);

  typedef struct packed {
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic signed [31:0] w;
  } vec3_t;

  localparam logic signed [63:0] RND = 64'sd1 <<< 29;

  vec3_t              pt_r  [4];
  vec3_t              ptm_r [4];
  trig_t              tg_r  [3];
  trig_t              tgm_r [3];
  logic signed [63:0] pc_r [4], qs_r [4], ps_r [4], qc_r [4];

  // rotation 0: (u,v) by -c; 1,2: (u,w) by b; 3: (u,v) by +c
  for (genvar j = 0; j < 4; j++) begin : g_rot
    localparam bit UV = (j == 0) || (j == 3);
    vec3_t              pin, pout;
    trig_t              tin;
    logic signed [31:0] p, q, c, s, np, nq;
    logic signed [63:0] ta, tb;

    if (j == 0) begin : g_first
      assign pin.u = px_i;
      assign pin.v = py_i;
      assign pin.w = '0;
      assign tin   = trig_i;
    end else begin : g_next
      assign pin = pt_r[j-1];
      assign tin = tg_r[j-1];
    end

    always_comb begin
      p = pin.u;
      q = UV ? pin.v : pin.w;
      c = UV ? tin.cc : tin.cb;
      if (j == 0) begin
        s = -tin.sc;
      end else if (j == 3) begin
        s = tin.sc;
      end else begin
        s = tin.sb;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pc_r[j]  <= 64'(p) * 64'(c);
        qs_r[j]  <= 64'(q) * 64'(s);
        ps_r[j]  <= 64'(p) * 64'(s);
        qc_r[j]  <= 64'(q) * 64'(c);
        ptm_r[j] <= pin;
      end
    end

    always_comb begin
      ta   = (pc_r[j] - qs_r[j] + RND) >>> 30;
      tb   = (ps_r[j] + qc_r[j] + RND) >>> 30;
      np   = ta[31:0];
      nq   = tb[31:0];
      pout = ptm_r[j];
      pout.u = np;
      if (UV) begin
        pout.v = nq;
      end else if (j == 1) begin
        pout.w = nq + lg_i;  // translate along the pole
      end else begin
        pout.w = nq;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pt_r[j] <= pout;
      end
    end

    if (j < 3) begin : g_trig
      always_ff @(posedge clk) begin
        if (en) begin
          tgm_r[j] <= tin;
          tg_r[j]  <= tgm_r[j];
        end
      end
    end
  end

  logic signed [32:0] du, dv, dw;
  logic [63:0]        sqa_r, sqb_r, sqc_r;
  logic [63:0]        tot;
  logic [SQ_IN_W-1:0] sum_r;

  assign du = 33'(px_i) - 33'(pt_r[3].u);
  assign dv = 33'(py_i) - 33'(pt_r[3].v);
  assign dw = -33'(pt_r[3].w);

  always_ff @(posedge clk) begin
    if (en) begin
      sqa_r <= unsigned'(64'(du) * 64'(du));
      sqb_r <= unsigned'(64'(dv) * 64'(dv));
      sqc_r <= unsigned'(64'(dw) * 64'(dw));
      sum_r <= tot[SQ_IN_W-1:0];
    end
  end

  assign tot   = sqa_r + sqb_r + sqc_r;
  assign sum_o = sum_r;

endmodule

[design/tpik_counts.sv]
// ----------------------------------------------------------------------------
// tpik_counts
// Tendon length to motor counts: rest minus length, scale, round, saturate.
// ----------------------------------------------------------------------------
module tpik_counts import tpik_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [SQ_ROOT_W-1:0] len_i,
  input  logic [15:0]          rest_i,
  input  logic [31:0]          cpm_i,
  output logic signed [23:0]   cnt_o
);

  localparam logic signed [63:0] RND  = 64'sd1 <<< (CNT_SHIFT - 1);
  localparam logic signed [63:0] VMAX = 64'sd8388607;
  localparam logic signed [63:0] VMIN = -64'sd8388608;

  logic signed [29:0] diff;
  logic signed [63:0] prod_r, v;
  logic signed [23:0] cnt_r;

  assign diff = signed'(30'({rest_i, {GUARD{1'b0}}})) - signed'(30'(len_i));

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'(diff) * 64'(signed'({1'b0, cpm_i}));
    end
  end

  assign v = (prod_r + RND) >>> CNT_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (v > VMAX) begin
        cnt_r <= VMAX[23:0];
      end else if (v < VMIN) begin
        cnt_r <= VMIN[23:0];
      end else begin
        cnt_r <= v[23:0];
      end
    end
  end

  assign cnt_o = cnt_r;

endmodule

[design/tilt_platform_inverse_kinematics.sv]
// ----------------------------------------------------------------------------
// tilt_platform_inverse_kinematics
// Two-tendon bending pole: target tip x/y to two saturated motor counts.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  in_     | in  | tvalid/tready      | tdata: target_x[15:0], target_y[31:16]
//  out_    | out | tvalid/tready      | tdata: motor_a[23:0], motor_b[47:24];
//          |     |                    | tuser: out_of_reach
//  cfg_    | in  | APB, pready tied 1 | 4 regs at byte address 4*i
//
// One request enters per clock unless the output buffer is full; it passes
// two 28-stage square roots and two 17-stage CORDICs. A single pipeline
// enable moves every stage; valid bits ride alongside. The enable drops only
// when the two-slot output buffer is full, so a request is still taken while
// one finished result waits; nothing is dropped or doubled under stalls.
// Synchronous active-low reset clears valids and loads register defaults. The
// user must write config only while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
module tilt_platform_inverse_kinematics import tpik_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // target_x[15:0], target_y[31:16]
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,    // motor_a_counts[23:0], motor_b_counts[47:24]
  output logic        out_tuser,    // out_of_reach
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int TOTAL   = 2 + 2 * SQ_LAT + 2 * CORDIC_LAT + TEN_LAT + CNT_LAT;
  localparam int C_DLY   = SQ_LAT - CORDIC_LAT;  // aligns atan2(x,y) with roots
  localparam int OOR_DLY = TOTAL - 2;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] pole_r, radius_r, rest_r;
  logic [31:0] cpm_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_r   <= 16'd0;
      radius_r <= 16'd0;
      rest_r   <= 16'd30720;
      cpm_r    <= 32'd478495703;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_POLE_LENGTH:   pole_r   <= cfg_pwdata[15:0];
        REG_ANCHOR_RADIUS: radius_r <= cfg_pwdata[15:0];
        REG_REST_LENGTH:   rest_r   <= cfg_pwdata[15:0];
        REG_COUNTS_PER_MM: cpm_r    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_POLE_LENGTH:   cfg_prdata = {16'd0, pole_r};
      REG_ANCHOR_RADIUS: cfg_prdata = {16'd0, radius_r};
      REG_REST_LENGTH:   cfg_prdata = {16'd0, rest_r};
      REG_COUNTS_PER_MM: cfg_prdata = cpm_r;
      default:           cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline enable and valid line
  // --------------------------------------------------------------------------
  logic             en;
  logic [TOTAL-1:0] vld_r;
  logic             skid_valid_r;

  assign en        = ~skid_valid_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOTAL-2:0], in_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // front end: squares, reach test
  // --------------------------------------------------------------------------
  logic signed [15:0] tx, ty, x1_r, y1_r, x2_r, y2_r;
  logic [31:0]        xx_r, yy_r, l2_r, r2_r, d_r;
  logic [32:0]        r2_sum;
  logic               oor2_r;

  assign tx = signed'(in_tdata[15:0]);
  assign ty = signed'(in_tdata[31:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= tx;
      y1_r <= ty;
      xx_r <= unsigned'(32'(tx) * 32'(tx));
      yy_r <= unsigned'(32'(ty) * 32'(ty));
      l2_r <= 32'(pole_r) * 32'(pole_r);
    end
  end

  assign r2_sum = 33'(xx_r) + 33'(yy_r);  // at most 2^31, top bit stays clear

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      r2_r   <= r2_sum[31:0];
      oor2_r <= r2_sum[31:0] > l2_r;
      d_r    <= l2_r - r2_sum[31:0];
    end
  end

  // --------------------------------------------------------------------------
  // tip height z, radial distance r, and angle a
  // --------------------------------------------------------------------------
  logic [SQ_ROOT_W-1:0]    z_root, r_root;
  logic signed [ANG_W-1:0] ang_a, ang_b;
  logic [31:0]             c_ang;
  logic [31:0]             c_dly_r [C_DLY];

  tpik_isqrt u_sqrt_z (
    .clk(clk), .en(en), .val_i(SQ_IN_W'(d_r)), .root_o(z_root)
  );

  tpik_isqrt u_sqrt_r (
    .clk(clk), .en(en), .val_i(SQ_IN_W'(r2_r)), .root_o(r_root)
  );

  tpik_cordic_vec u_vec_a (
    .clk(clk), .en(en),
    .xv_i({y2_r[15], y2_r, 16'h0000}),
    .yv_i({x2_r[15], x2_r, 16'h0000}),
    .ang_o(ang_a)
  );

  // c = a + pi with a = -atan2(x, y)
  assign c_ang = (32'd0 - ang_a[31:0]) + 32'h8000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      c_dly_r[0] <= c_ang;
      for (int k = 1; k < C_DLY; k++) begin
        c_dly_r[k] <= c_dly_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // angle b, then sin/cos of both angles
  // --------------------------------------------------------------------------
  logic signed [TRIG_W-1:0] cc, sc, cb, sb;
  logic signed [TRIG_W-1:0] cc_dly_r [CORDIC_LAT];
  logic signed [TRIG_W-1:0] sc_dly_r [CORDIC_LAT];

  tpik_cordic_vec u_vec_b (
    .clk(clk), .en(en),
    .xv_i({1'b0, z_root[15:0], 16'h0000}),
    .yv_i({1'b0, r_root[15:0], 16'h0000}),
    .ang_o(ang_b)
  );

  tpik_cordic_rot u_rot_c (
    .clk(clk), .en(en), .th_i(c_dly_r[C_DLY-1]), .cos_o(cc), .sin_o(sc)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      cc_dly_r[0] <= cc;
      sc_dly_r[0] <= sc;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        cc_dly_r[k] <= cc_dly_r[k-1];
        sc_dly_r[k] <= sc_dly_r[k-1];
      end
    end
  end

  tpik_cordic_rot u_rot_b (
    .clk(clk), .en(en), .th_i(ang_b[31:0]), .cos_o(cb), .sin_o(sb)
  );

  // --------------------------------------------------------------------------
  // tendons: anchors at (+radius, 0) and (0, +radius)
  // --------------------------------------------------------------------------
  trig_t              trig;
  logic signed [31:0] rad, lg;
  logic [SQ_IN_W-1:0] sum_a, sum_b;
  logic [SQ_ROOT_W-1:0] len_a, len_b;
  logic signed [23:0] cnt_a, cnt_b;

  assign trig.cc = cc_dly_r[CORDIC_LAT-1];
  assign trig.sc = sc_dly_r[CORDIC_LAT-1];
  assign trig.cb = cb;
  assign trig.sb = sb;
  assign rad     = signed'(32'({radius_r, {GUARD{1'b0}}}));
  assign lg      = signed'(32'({pole_r, {GUARD{1'b0}}}));

  tpik_tendon u_tendon_a (
    .clk(clk), .en(en), .px_i(rad), .py_i(32'sd0), .lg_i(lg),
    .trig_i(trig), .sum_o(sum_a)
  );

  tpik_tendon u_tendon_b (
    .clk(clk), .en(en), .px_i(32'sd0), .py_i(rad), .lg_i(lg),
    .trig_i(trig), .sum_o(sum_b)
  );

  tpik_isqrt u_sqrt_la (.clk(clk), .en(en), .val_i(sum_a), .root_o(len_a));
  tpik_isqrt u_sqrt_lb (.clk(clk), .en(en), .val_i(sum_b), .root_o(len_b));

  tpik_counts u_counts_a (
    .clk(clk), .en(en), .len_i(len_a), .rest_i(rest_r), .cpm_i(cpm_r), .cnt_o(cnt_a)
  );

  tpik_counts u_counts_b (
    .clk(clk), .en(en), .len_i(len_b), .rest_i(rest_r), .cpm_i(cpm_r), .cnt_o(cnt_b)
  );

  // reach flag follows the request to the end
  logic oor_dly_r [OOR_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      oor_dly_r[0] <= oor2_r;
      for (int k = 1; k < OOR_DLY; k++) begin
        oor_dly_r[k] <= oor_dly_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register plus skid slot
  // --------------------------------------------------------------------------
  logic               push, oor_fin, take;
  logic signed [23:0] fin_a, fin_b;
  logic               out_valid_r, out_oor_r, skid_oor_r;
  logic signed [23:0] out_ma_r, out_mb_r, skid_ma_r, skid_mb_r;

  assign oor_fin = oor_dly_r[OOR_DLY-1];
  assign fin_a   = oor_fin ? 24'sd0 : cnt_a;
  assign fin_b   = oor_fin ? 24'sd0 : cnt_b;
  assign push    = en & vld_r[TOTAL-1];
  assign take    = out_valid_r & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_ma_r  <= skid_ma_r;
        out_mb_r  <= skid_mb_r;
        out_oor_r <= skid_oor_r;
      end else begin
        out_ma_r  <= fin_a;
        out_mb_r  <= fin_b;
        out_oor_r <= oor_fin;
      end
    end else if (push) begin
      skid_ma_r  <= fin_a;
      skid_mb_r  <= fin_b;
      skid_oor_r <= oor_fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_mb_r, out_ma_r};
  assign out_tuser  = out_oor_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot holds a result while output is empty");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |-> (out_ma_r == 24'sd0 && out_mb_r == 24'sd0))
    else $error("out of reach result carries non-zero counts");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valids moved during a stall");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tilt platform IK pipeline: directed targets,
// then random ones over several register settings, each result checked
// against a bit-true predictor under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top import tpik_pkg::*; ();

  localparam int LATENCY = 104;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  always #4 clk = ~clk;

  tilt_platform_inverse_kinematics dut (.*);

  typedef struct packed {
    logic signed [23:0] motor_a;
    logic signed [23:0] motor_b;
    logic               unreachable;
  } motor_cmd_t;

  // Shadow registers mirroring the block's configuration
  longint unsigned sh_pole, sh_radius, sh_rest, sh_cpm;

  motor_cmd_t pending_cmds[$];
  int  n_errors = 0;
  int  out_gap = 0;

  localparam longint ATAN_ANG [24] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
    64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
  };

  // arithmetic shift right, rounding toward minus infinity
  function automatic longint sra(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_sr(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // vectoring CORDIC: binary angle of (xv, yv)
  function automatic longint bearing(longint xv, longint yv);
    longint acc, t, nx, ny;
    acc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; acc = 64'sh40000000;
      end else begin
        xv = -yv; yv = t; acc = -64'sh40000000;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (yv > 0) begin
        nx = xv + sra(yv, i); ny = yv - sra(xv, i); acc += ATAN_ANG[i];
      end else begin
        nx = xv - sra(yv, i); ny = yv + sra(xv, i); acc -= ATAN_ANG[i];
      end
      xv = nx; yv = ny;
    end
    return acc;
  endfunction

  // rotation CORDIC: Q30 cos/sin of a 32-bit binary angle
  function automatic void cos_sin(input logic [31:0] th, output longint co,
                                  output longint si);
    longint zz, xx, yy, nx, ny;
    bit     flip;
    zz = longint'(th);
    xx = 652032874;
    yy = 0;
    flip = 1'b0;
    if (zz >= 64'sh80000000) zz -= 64'sh100000000;
    if (zz > 64'sh40000000) begin
      zz -= 64'sh80000000; flip = 1'b1;
    end else if (zz < -64'sh40000000) begin
      zz += 64'sh80000000; flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (zz >= 0) begin
        nx = xx - sra(yy, i); ny = yy + sra(xx, i); zz -= ATAN_ANG[i];
      end else begin
        nx = xx + sra(yy, i); ny = yy - sra(xx, i); zz += ATAN_ANG[i];
      end
      xx = nx; yy = ny;
    end
    co = flip ? -xx : xx;
    si = flip ? -yy : yy;
  endfunction

  function automatic void rotate(inout longint p, inout longint q, input longint c,
                                 input longint s);
    longint np, nq;
    np = round_sr(p * c - q * s, 30);
    nq = round_sr(p * s + q * c, 30);
    p = np;
    q = nq;
  endfunction

  // length of the tendon from anchor (px, py) after the tip transform
  function automatic longint unsigned tendon_len(longint px, longint py, longint lg,
      longint cc, longint sc, longint cb, longint sb);
    longint u, v, w, du, dv, dw;
    u = px; v = py; w = 0;
    rotate(u, v, cc, -sc);
    rotate(u, w, cb, sb);
    w += lg;
    rotate(u, w, cb, sb);
    rotate(u, v, cc, sc);
    du = px - u; dv = py - v; dw = -w;
    return int_sqrt(longint'(du * du) + longint'(dv * dv) + longint'(dw * dw));
  endfunction

  function automatic logic signed [23:0] length_to_counts(longint unsigned len);
    longint diff, v;
    diff = longint'(sh_rest << GUARD) - longint'(len);
    v = round_sr(diff * longint'(sh_cpm), CNT_SHIFT);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic motor_cmd_t solve_ik(logic signed [15:0] tx, logic signed [15:0] ty);
    motor_cmd_t r;
    longint x, y, z, rr, ang_a, ang_b, cc, sc, cb, sb, rad, lg;
    longint unsigned r2, l2;
    logic [31:0] c;
    x = tx; y = ty;
    r2 = x * x + y * y;
    l2 = sh_pole * sh_pole;
    r = '0;
    if (r2 > l2) begin
      r.unreachable = 1'b1;
      return r;
    end
    z = int_sqrt(l2 - r2);
    rr = int_sqrt(r2);
    ang_a = bearing(y * 65536, x * 65536);
    c = (32'd0 - ang_a[31:0]) + 32'h80000000;
    ang_b = bearing(z * 65536, rr * 65536);
    cos_sin(c, cc, sc);
    cos_sin(ang_b[31:0], cb, sb);
    rad = sh_radius << GUARD;
    lg = sh_pole << GUARD;
    r.motor_a = length_to_counts(tendon_len(rad, 0, lg, cc, sc, cb, sb));
    r.motor_b = length_to_counts(tendon_len(0, rad, lg, cc, sc, cb, sb));
    return r;
  endfunction

  // APB write: setup then access cycle; shadow updated in step
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_POLE_LENGTH:   sh_pole   = val[15:0];
      REG_ANCHOR_RADIUS: sh_radius = val[15:0];
      REG_REST_LENGTH:   sh_rest   = val[15:0];
      REG_COUNTS_PER_MM: sh_cpm    = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] pl, logic [15:0] ar, logic [15:0] rl,
                            logic [31:0] cpm);
    reg_write(REG_POLE_LENGTH, pl);
    reg_write(REG_ANCHOR_RADIUS, ar);
    reg_write(REG_REST_LENGTH, rl);
    reg_write(REG_COUNTS_PER_MM, cpm);
  endtask

  // request driver; expectation queued at the accepting edge, valid stays up
  // when the next request follows with no gap
  task automatic send_target(logic signed [15:0] tx, logic signed [15:0] ty,
                             bit has_fixed, motor_cmd_t fixed);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ty, tx};
    do @(posedge clk); while (!in_tready);
    pending_cmds.push_back(has_fixed ? fixed : solve_ik(tx, ty));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // result sink, random wait drawn after each result
  always @(posedge clk) begin
    motor_cmd_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_cmds.size() == 0) begin
          $error("unexpected result %h", out_tdata);
          n_errors++;
        end else begin
          want = pending_cmds.pop_front();
          if (out_tdata[23:0] !== want.motor_a) begin
            $error("motor_a_counts exp %0d got %0d", want.motor_a,
                   $signed(out_tdata[23:0]));
            n_errors++;
          end
          if (out_tdata[47:24] !== want.motor_b) begin
            $error("motor_b_counts exp %0d got %0d", want.motor_b,
                   $signed(out_tdata[47:24]));
            n_errors++;
          end
          if (out_tuser !== want.unreachable) begin
            $error("out_of_reach exp %0b got %0b", want.unreachable, out_tuser);
            n_errors++;
          end
        end
        out_gap = $urandom_range(0, 5);
      end else if (out_gap > 0) begin
        out_gap--;
      end
      out_tready <= (out_gap == 0);
    end
  end

  typedef struct {
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    bit                 fixed;
    motor_cmd_t         res;
  } target_row_t;

  // directed targets under pole 30000, radius 1000 (rows with fixed results
  // are out of reach: zero counts, flag set)
  target_row_t dir_rows[] = '{
    '{16'sd0,      16'sd0,      1'b0, '0},
    '{16'sd30000,  16'sd0,      1'b0, '0},   // on the boundary, z = 0
    '{16'sd0,      -16'sd30000, 1'b0, '0},
    '{-16'sd30000, 16'sd0,      1'b0, '0},
    '{16'sd0,      16'sd30000,  1'b0, '0},
    '{16'sd30001,  16'sd0,      1'b1, '{24'sd0, 24'sd0, 1'b1}},
    '{16'sd32767,  16'sd32767,  1'b1, '{24'sd0, 24'sd0, 1'b1}},
    '{-16'sd32768, -16'sd32768, 1'b1, '{24'sd0, 24'sd0, 1'b1}},
    '{-16'sd32768, 16'sd0,      1'b1, '{24'sd0, 24'sd0, 1'b1}},
    '{16'sd21213,  16'sd21213,  1'b0, '0},
    '{-16'sd1,     -16'sd1,     1'b0, '0},
    '{16'sd1,      -16'sd1,     1'b0, '0},
    '{-16'sd15000, 16'sd20000,  1'b0, '0},
    '{-16'sd100,   -16'sd29000, 1'b0, '0}
  };

  function automatic logic signed [15:0] rand_coord(longint unsigned pole);
    int lim;
    if ($urandom_range(0, 9) == 0) return 16'($urandom());   // anything, mostly out of reach
    lim = (pole > 32767) ? 32767 : int'(pole);
    return $signed(16'($urandom_range(0, 2 * lim))) - 16'(lim);
  endfunction

  initial begin
    sh_pole = 0; sh_radius = 0; sh_rest = 30720; sh_cpm = 478495703;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: zero pole, only the origin is reachable
    send_target(16'sd0, 16'sd0, 1'b0, '0);
    send_target(16'sd1, 16'sd0, 1'b1, '{24'sd0, 24'sd0, 1'b1});
    drain();

    set_config(16'd30000, 16'd1000, 16'd30720, 32'd478495703);
    foreach (dir_rows[i])
      send_target(dir_rows[i].tx, dir_rows[i].ty, dir_rows[i].fixed, dir_rows[i].res);
    drain();

    // random phases over assorted settings, extremes included
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_config(16'd30000, 16'd1000, 16'd30720, 32'd478495703);
        1: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
        2: set_config(16'd0, 16'd0, 16'd0, 32'd0);
        3: set_config(16'd5000, 16'hFFFF, 16'd0, 32'hFFFFFFFF);
        4: set_config(16'hFFFF, 16'd0, 16'hFFFF, 32'd1);
        default: set_config(16'($urandom()), 16'($urandom()), 16'($urandom()),
                            $urandom());
      endcase
      repeat (200) send_target(rand_coord(sh_pole), rand_coord(sh_pole), 1'b0, '0);
      drain();
    end
    if (n_errors == 0) $display("** tilt_platform_inverse_kinematics: PASSED **");
    else $display("** tilt_platform_inverse_kinematics: FAILED **");
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("** tilt_platform_inverse_kinematics: FAILED **");
    $finish;
  end

endmodule
